// File: hdl/bal_pkg.sv
package bal_pkg;

    // List capacity and the widths that follow from it.
    localparam int DEPTH   = 16;
    localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int DATA_W  = 32;
    localparam int OP_W    = 3;
    localparam int COUNT_W = 5;

    typedef enum logic [OP_W-1:0] {
        OP_APPEND      = 3'd0,
        OP_FRONT       = 3'd1,
        OP_SORTED_INS  = 3'd2,
        OP_REMOVE      = 3'd3,
        OP_SORTED_REM  = 3'd4,
        OP_REMOVE_MIN  = 3'd5,
        OP_REMOVE_EVEN = 3'd6,
        OP_REMOVE_ALL  = 3'd7
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SCAN_WAIT,
        ST_DECIDE,
        ST_MOVE,
        ST_MOVE_WAIT,
        ST_FINISH,
        ST_RESULT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic start;
        logic rd;
        logic move;
        logic decide;
        logic finish;
        logic load;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic used_zero;
        logic ra_last;
        logic dec_ok;
        logic dec_none;
    } t_status;

    // Operations that need a search pass over the list before they modify it.
    function automatic logic op_needs_scan(input t_op op);
        logic res;
        case (op)
            OP_SORTED_INS, OP_REMOVE, OP_SORTED_REM, OP_REMOVE_MIN: res = 1'b1;
            default: res = 1'b0;
        endcase
        return res;
    endfunction

    function automatic logic op_is_insert(input t_op op);
        logic res;
        case (op)
            OP_APPEND, OP_FRONT, OP_SORTED_INS: res = 1'b1;
            default: res = 1'b0;
        endcase
        return res;
    endfunction

endpackage

// File: hdl/bal_in_if.sv
interface bal_in_if;
    import bal_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [OP_W-1:0]          op;
    logic signed [DATA_W-1:0] value;

    modport source (output valid, output op, output value, input ready);
    modport sink   (input valid, input op, input value, output ready);
endinterface

// File: hdl/bal_out_if.sv
interface bal_out_if;
    import bal_pkg::*;

    logic               valid;
    logic               ready;
    logic               ok;
    logic [COUNT_W-1:0] count;
    logic               is_empty;
    logic               is_full;

    modport source (output valid, output ok, output count, output is_empty, output is_full,
                    input ready);
    modport sink   (input valid, input ok, input count, input is_empty, input is_full,
                    output ready);
endinterface

// File: hdl/bounded_array_list_engine.sv
// Bounded list of up to 16 signed 32-bit values, packed from index 0, kept in a
// memory with one read port and one write port, used once each per cycle. Each
// transfer on the input channel carries one operation and produces exactly one result
// transfer with the success flag and the count, empty and full flags after the operation.
// Sorted insert, remove first, sorted remove and remove minimum first read the
// whole list to find their position, then every operation that succeeds reads
// the entries from that position upward once to shift or pack them. A failed
// insert or removal skips that pass and returns right after the search pass.
// The input is taken again as soon as the result sits in the output register,
// even if it has not been taken yet.
module bounded_array_list_engine
    import bal_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    bal_in_if.sink      i_in,
    bal_out_if.source   o_out
);

    t_cmd    cmd;
    t_status status;

    bal_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_op     (i_in.op),
        .o_in_ready  (i_in.ready),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    bal_dpath u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_op       (i_in.op),
        .i_value    (i_in.value),
        .o_status   (status),
        .o_ok       (o_out.ok),
        .o_count    (o_out.count),
        .o_is_empty (o_out.is_empty),
        .o_is_full  (o_out.is_full)
    );

endmodule

// File: hdl/bal_dpath.sv
module bal_dpath
    import bal_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cmd                     i_cmd,
    input  logic [OP_W-1:0]          i_op,
    input  logic signed [DATA_W-1:0] i_value,
    output t_status                  o_status,
    output logic                     o_ok,
    output logic [COUNT_W-1:0]       o_count,
    output logic                     o_is_empty,
    output logic                     o_is_full
);

    logic [DATA_W-1:0] mem [DEPTH];

    // Control state.
    logic [CNT_W-1:0] r_used;
    logic             r_rd_vld;
    logic             r_rd_move;

    // Operation and pass registers.
    t_op                      r_op;
    logic signed [DATA_W-1:0] r_val;
    logic [IDX_W-1:0]         r_ra;
    logic [IDX_W-1:0]         r_rd_idx;
    logic [DATA_W-1:0]        r_rdata;
    logic [CNT_W-1:0]         r_w;
    logic [DATA_W-1:0]        r_carry;
    logic [IDX_W-1:0]         r_del_idx;
    logic                     r_ok;

    // Search results.
    logic                     r_found_gt;
    logic [CNT_W-1:0]         r_pos_gt;
    logic                     r_found_eq;
    logic [IDX_W-1:0]         r_idx_eq;
    logic                     r_found_ge;
    logic [IDX_W-1:0]         r_idx_ge;
    logic                     r_ge_eq;
    logic                     r_ge_first;
    logic                     r_le_last;
    logic signed [DATA_W-1:0] r_best_val;
    logic [IDX_W-1:0]         r_best_idx;

    logic             d_lt;
    logic             d_eq;
    logic             d_less_best;
    logic             d_first;
    logic             d_last;
    logic             d_drop;
    logic             dec_ok;
    logic [CNT_W-1:0] dec_start;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [DATA_W-1:0] wr_data;

    assign d_lt        = $signed(r_rdata) < r_val;
    assign d_eq        = r_rdata == r_val;
    assign d_less_best = $signed(r_rdata) < r_best_val;
    assign d_first     = r_rd_idx == '0;
    assign d_last      = (CNT_W'(r_rd_idx) + CNT_W'(1)) == r_used;

    always_comb begin
        case (r_op)
            OP_REMOVE_EVEN: d_drop = ~r_rdata[0];
            OP_REMOVE_ALL:  d_drop = d_eq;
            default:        d_drop = (r_rd_idx == r_del_idx);
        endcase
    end

    // Outcome of the search pass and where the modify pass starts.
    always_comb begin
        dec_ok    = 1'b0;
        dec_start = '0;
        case (r_op)
            OP_APPEND: begin
                dec_ok    = r_used < CNT_W'(DEPTH);
                dec_start = r_used;
            end
            OP_FRONT: begin
                dec_ok    = r_used < CNT_W'(DEPTH);
                dec_start = '0;
            end
            OP_SORTED_INS: begin
                dec_ok    = r_used < CNT_W'(DEPTH);
                dec_start = r_pos_gt;
            end
            OP_REMOVE: begin
                dec_ok    = (r_used != '0) && r_found_eq;
                dec_start = CNT_W'(r_idx_eq);
            end
            OP_SORTED_REM: begin
                dec_ok    = (r_used != '0) && r_ge_first && r_le_last && r_found_ge && r_ge_eq;
                dec_start = CNT_W'(r_idx_ge);
            end
            OP_REMOVE_MIN: begin
                dec_ok    = r_used != '0;
                dec_start = CNT_W'(r_best_idx);
            end
            default: begin
                dec_ok    = r_used != '0;
                dec_start = '0;
            end
        endcase
    end

    assign o_status.used_zero = r_used == '0;
    assign o_status.ra_last   = (CNT_W'(r_ra) + CNT_W'(1)) == r_used;
    assign o_status.dec_ok    = dec_ok;
    assign o_status.dec_none  = dec_start == r_used;

    // Single write port: ripple during an insert, packing during a removal,
    // and the last entry of an insert at the end.
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_rd_idx;
        wr_data = r_rdata;
        if (r_rd_vld && r_rd_move) begin
            if (op_is_insert(r_op)) begin
                wr_en   = 1'b1;
                wr_addr = r_rd_idx;
                wr_data = r_carry;
            end else begin
                wr_en   = ~d_drop;
                wr_addr = r_w[IDX_W-1:0];
                wr_data = r_rdata;
            end
        end else if (i_cmd.finish && op_is_insert(r_op)) begin
            wr_en   = 1'b1;
            wr_addr = r_used[IDX_W-1:0];
            wr_data = r_carry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        r_rdata <= mem[r_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used    <= '0;
            r_rd_vld  <= 1'b0;
            r_rd_move <= 1'b0;
        end else begin
            r_rd_vld  <= i_cmd.rd;
            r_rd_move <= i_cmd.move;
            if (i_cmd.finish) begin
                if (op_is_insert(r_op)) begin
                    r_used <= r_used + CNT_W'(1);
                end else begin
                    r_used <= r_w;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_op       <= t_op'(i_op);
            r_val      <= i_value;
            r_ra       <= '0;
            r_found_gt <= 1'b0;
            r_pos_gt   <= r_used;
            r_found_eq <= 1'b0;
            r_found_ge <= 1'b0;
            r_ge_first <= 1'b0;
            r_le_last  <= 1'b0;
        end
        if (i_cmd.rd) begin
            r_ra     <= r_ra + IDX_W'(1);
            r_rd_idx <= r_ra;
        end
        if (i_cmd.decide) begin
            r_ra      <= dec_start[IDX_W-1:0];
            r_w       <= dec_start;
            r_del_idx <= dec_start[IDX_W-1:0];
            r_carry   <= r_val;
            r_ok      <= dec_ok;
        end
        if (r_rd_vld && !r_rd_move) begin
            if (!r_found_gt && !d_lt && !d_eq) begin
                r_found_gt <= 1'b1;
                r_pos_gt   <= CNT_W'(r_rd_idx);
            end
            if (!r_found_eq && d_eq) begin
                r_found_eq <= 1'b1;
                r_idx_eq   <= r_rd_idx;
            end
            if (!r_found_ge && !d_lt) begin
                r_found_ge <= 1'b1;
                r_idx_ge   <= r_rd_idx;
                r_ge_eq    <= d_eq;
            end
            if (d_first) begin
                r_ge_first <= d_lt | d_eq;
            end
            if (d_last) begin
                r_le_last <= ~d_lt;
            end
            if (d_first || d_less_best) begin
                r_best_val <= $signed(r_rdata);
                r_best_idx <= r_rd_idx;
            end
        end
        if (r_rd_vld && r_rd_move) begin
            if (op_is_insert(r_op)) begin
                r_carry <= r_rdata;
            end else if (!d_drop) begin
                r_w <= r_w + CNT_W'(1);
            end
        end
        if (i_cmd.load) begin
            o_ok       <= r_ok;
            o_count    <= COUNT_W'(r_used);
            o_is_empty <= r_used == '0;
            o_is_full  <= r_used == CNT_W'(DEPTH);
        end
    end

endmodule

// File: hdl/bal_ctrl.sv
module bal_ctrl
    import bal_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic [OP_W-1:0] i_in_op,
    output logic            o_in_ready,
    input  logic            i_out_ready,
    output logic            o_out_valid,
    input  t_status         i_status,
    output t_cmd            o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_out_vld;
    logic   n_out_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_out_vld  = r_out_vld && !i_out_ready;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.start = 1'b1;
                    if (i_status.used_zero || !op_needs_scan(t_op'(i_in_op))) begin
                        n_state = ST_DECIDE;
                    end else begin
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                o_cmd.rd = 1'b1;
                if (i_status.ra_last) begin
                    n_state = ST_SCAN_WAIT;
                end
            end
            ST_SCAN_WAIT: begin
                n_state = ST_DECIDE;
            end
            ST_DECIDE: begin
                o_cmd.decide = 1'b1;
                if (!i_status.dec_ok) begin
                    n_state = ST_RESULT;
                end else if (i_status.dec_none) begin
                    n_state = ST_FINISH;
                end else begin
                    n_state = ST_MOVE;
                end
            end
            ST_MOVE: begin
                o_cmd.rd   = 1'b1;
                o_cmd.move = 1'b1;
                if (i_status.ra_last) begin
                    n_state = ST_MOVE_WAIT;
                end
            end
            ST_MOVE_WAIT: begin
                n_state = ST_FINISH;
            end
            ST_FINISH: begin
                o_cmd.finish = 1'b1;
                n_state      = ST_RESULT;
            end
            ST_RESULT: begin
                // The result register frees up in the same cycle as its transfer.
                if (!r_out_vld || i_out_ready) begin
                    o_cmd.load = 1'b1;
                    n_out_vld  = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_vld;

endmodule

// File: sim/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import bal_pkg::*;

    localparam int N_ITEMS    = 450;
    localparam int PRINT_MAX  = 20;
    localparam int IDLE_PCT   = 9;
    localparam int HOLD_CYCLES = 250;

    typedef struct {
        t_op                      op;
        logic signed [DATA_W-1:0] value;
    } t_list_req;

    typedef struct packed {
        logic               ok;
        logic [COUNT_W-1:0] count;
        logic               is_empty;
        logic               is_full;
    } t_list_status;

    logic i_clk = 1'b0;
    logic i_rst_n;

    bal_in_if  in_ch ();
    bal_out_if out_ch ();

    bounded_array_list_engine i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    t_list_req                req_q[$];
    t_list_status             status_q[$];
    logic signed [DATA_W-1:0] shadow_list[$];
    logic signed [DATA_W-1:0] recent_vals[$];
    int                       count_bound;

    int   mismatches;
    int   results_seen;
    int   full_seen;
    int   empty_seen;
    int   rejected_seen;
    int   op_hits[8];
    logic calm;
    logic drain_hold;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Applies one operation to the shadow list and returns the status the block must report.
    function automatic t_list_status list_step(input t_op op,
                                               input logic signed [DATA_W-1:0] v);
        t_list_status             res;
        int                       pos;
        int                       best;
        logic signed [DATA_W-1:0] kept[$];
        res.ok = 1'b0;
        if (op inside {OP_APPEND, OP_FRONT, OP_SORTED_INS}) begin
            if (shadow_list.size() < DEPTH) begin
                res.ok = 1'b1;
                if (op == OP_APPEND) begin
                    shadow_list.push_back(v);
                end else if (op == OP_FRONT) begin
                    shadow_list.push_front(v);
                end else begin
                    // Equal values stay ahead of the new one.
                    pos = 0;
                    while (pos < shadow_list.size() && shadow_list[pos] <= v) pos++;
                    shadow_list.insert(pos, v);
                end
            end
        end else if (shadow_list.size() != 0) begin
            case (op)
                OP_REMOVE: begin
                    pos = 0;
                    while (pos < shadow_list.size() && shadow_list[pos] != v) pos++;
                    if (pos < shadow_list.size()) begin
                        shadow_list.delete(pos);
                        res.ok = 1'b1;
                    end
                end
                OP_SORTED_REM: begin
                    // Out of the range spanned by the ends, the search is skipped.
                    if (v >= shadow_list[0] && v <= shadow_list[shadow_list.size() - 1]) begin
                        pos = 0;
                        while (pos < shadow_list.size() && shadow_list[pos] < v) pos++;
                        if (pos < shadow_list.size() && shadow_list[pos] == v) begin
                            shadow_list.delete(pos);
                            res.ok = 1'b1;
                        end
                    end
                end
                OP_REMOVE_MIN: begin
                    best = 0;
                    for (pos = 1; pos < shadow_list.size(); pos++)
                        if (shadow_list[pos] < shadow_list[best]) best = pos;
                    shadow_list.delete(best);
                    res.ok = 1'b1;
                end
                OP_REMOVE_EVEN: begin
                    foreach (shadow_list[k])
                        if (shadow_list[k][0]) kept.push_back(shadow_list[k]);
                    shadow_list = kept;
                    res.ok = 1'b1;
                end
                OP_REMOVE_ALL: begin
                    foreach (shadow_list[k])
                        if (shadow_list[k] != v) kept.push_back(shadow_list[k]);
                    shadow_list = kept;
                    res.ok = 1'b1;
                end
                default: begin
                end
            endcase
        end
        res.count    = COUNT_W'(shadow_list.size());
        res.is_empty = (shadow_list.size() == 0);
        res.is_full  = (shadow_list.size() == DEPTH);
        return res;
    endfunction

    // Values lean toward ones already inserted so that removals find matches.
    function automatic logic signed [DATA_W-1:0] pick_value();
        int                       r;
        logic signed [DATA_W-1:0] v;
        r = $urandom_range(99);
        if (r < 45 && recent_vals.size() != 0) begin
            v = recent_vals[$urandom_range(recent_vals.size() - 1)];
        end else if (r < 75) begin
            case ($urandom_range(7))
                0: v = -2;
                1: v = -1;
                2: v = 0;
                3: v = 1;
                4: v = 2;
                5: v = 3;
                6: v = 32'sh8000_0000;
                default: v = 32'sh7fff_ffff;
            endcase
        end else begin
            v = $urandom;
        end
        return v;
    endfunction

    task automatic add_req(input t_op op, input logic signed [DATA_W-1:0] v);
        t_list_req r;
        r.op    = op;
        r.value = v;
        req_q.push_back(r);
        if (op inside {OP_APPEND, OP_FRONT, OP_SORTED_INS}) begin
            recent_vals.push_back(v);
            if (recent_vals.size() > 32) recent_vals.delete(0);
            if (count_bound < DEPTH) count_bound++;
        end
    endtask

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= PRINT_MAX) $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    // Input driver: a held transfer stays on the bus until the block takes it.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                status_q.push_back(list_step(req_q[0].op, req_q[0].value));
                op_hits[req_q[0].op]++;
                req_q.delete(0);
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (req_q.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
                    in_ch.valid <= 1'b1;
                    in_ch.op    <= req_q[0].op;
                    in_ch.value <= req_q[0].value;
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor.
    always @(posedge i_clk) begin : result_monitor
        t_list_status want;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                results_seen++;
                if (status_q.size() == 0) begin
                    report_mismatch("result transfer with no operation outstanding");
                end else begin
                    want = status_q.pop_front();
                    if (out_ch.ok !== want.ok)
                        report_mismatch($sformatf("result %0d: ok %b, wanted %b",
                                                  results_seen, out_ch.ok, want.ok));
                    if (out_ch.count !== want.count)
                        report_mismatch($sformatf("result %0d: count %0d, wanted %0d",
                                                  results_seen, out_ch.count, want.count));
                    if (out_ch.is_empty !== want.is_empty)
                        report_mismatch($sformatf("result %0d: empty %b, wanted %b",
                                                  results_seen, out_ch.is_empty,
                                                  want.is_empty));
                    if (out_ch.is_full !== want.is_full)
                        report_mismatch($sformatf("result %0d: full %b, wanted %b",
                                                  results_seen, out_ch.is_full,
                                                  want.is_full));
                    if (want.is_full) full_seen++;
                    if (want.is_empty) empty_seen++;
                    if (!want.ok) rejected_seen++;
                end
            end
            out_ch.ready <= !drain_hold && (calm || $urandom_range(99) >= IDLE_PCT);
        end
    end

    // A window without any idling, then a long output stall that backs up the input.
    initial begin
        calm       = 1'b0;
        drain_hold = 1'b0;
        while (results_seen < 100) @(posedge i_clk);
        calm <= 1'b1;
        while (results_seen < 190) @(posedge i_clk);
        calm <= 1'b0;
        while (results_seen < 280) @(posedge i_clk);
        drain_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        drain_hold <= 1'b0;
    end

    initial begin
        #5ms;
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        int n;
        int len;
        int kind;
        int r;
        int fewest;
        i_rst_n      = 1'b0;
        count_bound  = 0;

        // Every removal on an empty list.
        add_req(OP_REMOVE, 0);
        add_req(OP_SORTED_REM, 0);
        add_req(OP_REMOVE_MIN, 0);
        add_req(OP_REMOVE_EVEN, 0);
        add_req(OP_REMOVE_ALL, 0);
        // Build an ordered list from the extremes, with a duplicate.
        add_req(OP_APPEND, 32'sh7fff_ffff);
        add_req(OP_FRONT, 32'sh8000_0000);
        add_req(OP_SORTED_INS, 0);
        add_req(OP_SORTED_INS, -1);
        add_req(OP_SORTED_INS, 0);
        add_req(OP_SORTED_REM, 5);
        add_req(OP_SORTED_REM, 0);
        add_req(OP_REMOVE, 32'sh7fff_ffff);
        add_req(OP_SORTED_REM, 32'sh7fff_ffff);
        add_req(OP_REMOVE, 12345);
        add_req(OP_REMOVE_MIN, 0);
        // A negative even value must go with the evens.
        add_req(OP_FRONT, -2);
        add_req(OP_REMOVE_EVEN, 0);
        add_req(OP_SORTED_REM, -5);
        add_req(OP_REMOVE_ALL, 7);
        add_req(OP_REMOVE_ALL, -1);

        // Fill to capacity, then try every insert on the full list.
        for (n = 0; n < DEPTH; n++) add_req(OP_APPEND, pick_value());
        add_req(OP_FRONT, pick_value());
        add_req(OP_SORTED_INS, pick_value());
        add_req(OP_APPEND, pick_value());

        while (req_q.size() < N_ITEMS) begin
            kind = $urandom_range(9);
            if (kind < 5) begin
                // Sorted runs start from an empty list so that sorted remove sees order.
                for (n = 0; n < count_bound; n++) add_req(OP_REMOVE_MIN, pick_value());
                count_bound = 0;
                len = $urandom_range(30, 8);
                for (n = 0; n < len; n++) begin
                    r = $urandom_range(99);
                    if (r < 50)      add_req(OP_SORTED_INS, pick_value());
                    else if (r < 75) add_req(OP_SORTED_REM, pick_value());
                    else if (r < 82) add_req(OP_REMOVE, pick_value());
                    else if (r < 88) add_req(OP_REMOVE_MIN, pick_value());
                    else if (r < 94) add_req(OP_REMOVE_EVEN, pick_value());
                    else             add_req(OP_REMOVE_ALL, pick_value());
                end
            end else if (kind < 7) begin
                len = $urandom_range(20, 12);
                for (n = 0; n < len; n++)
                    add_req($urandom_range(1) ? OP_APPEND : OP_FRONT, pick_value());
                len = $urandom_range(6, 2);
                for (n = 0; n < len; n++) add_req(t_op'($urandom_range(7, 3)), pick_value());
            end else begin
                len = $urandom_range(15, 6);
                for (n = 0; n < len; n++) add_req(t_op'($urandom_range(7)), pick_value());
            end
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (req_q.size() != 0 || status_q.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);

        fewest = op_hits[0];
        foreach (op_hits[k]) if (op_hits[k] < fewest) fewest = op_hits[k];
        $display("Ran %0d list operations with %0d results checked;",
                 results_seen, results_seen - status_q.size());
        $display("every operation kind ran %0d times or more.", fewest);
        $display("The list stood full after %0d operations and empty after %0d;",
                 full_seen, empty_seen);
        $display("%0d operations were refused.", rejected_seen);
        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// File: filelist.f
hdl/bal_pkg.sv
hdl/bal_in_if.sv
hdl/bal_out_if.sv
hdl/bal_dpath.sv
hdl/bal_ctrl.sv
hdl/bounded_array_list_engine.sv
sim/testbench.sv
